### rtl/vcrd_pkg.sv
// Shared types and constants of the vector clock race detector.
`timescale 1ns / 1ps

package vcrd_pkg;

    // Parameter defaults
    localparam int THREADS_DEF       = 4;
    localparam int CLOCK_BITS_DEF    = 16;
    localparam int LOCATION_BITS_DEF = 10;

    // Fixed port widths
    localparam int THR_W  = 2;
    localparam int SLOT_W = 16;
    localparam int VEC_W  = 4 * SLOT_W;
    localparam int LOC_W  = 10;

    // Result buffer
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // One race report: the earlier access that conflicts
    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [SLOT_W-1:0] clk;
        logic              was_write;
    } t_report;

    // Races found for one item, in reporting order
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_report [MAX_RESULTS-1:0]       rep;
    } t_race_list;

endpackage

### rtl/vector_clock_race_detector.sv
// Top level of the vector clock race detector: control, shadow memories, result path.
`timescale 1ns / 1ps

// Each input item is one memory access: kind (read/write), thread, shadow
// location and the thread's packed vector clock. For every location the block
// keeps the last write epoch and one read clock per thread in two RAMs.
// Each item gives one or more result items: one per race found (race_found 1),
// at most four, or a single acknowledgement (race_found 0); o_last marks the
// final one. The shadow entry is read at the accepting edge, checked and
// written back at the next edge, which also loads the first result;
// o_out_valid rises once that result is loaded.
// The single read-modify-write of the shadow entry (read at the accept edge,
// write back on the following one) keeps a new item out until the last one is
// checked and written back, and results are handed over one at a time. A new
// item is taken while the last result of the previous one is being handed over.
// Reset: after i_rst_n the shadow RAMs are cleared, one location a cycle, over
// all 2**LOCATION_BITS locations (1024 by default); o_in_ready stays low meanwhile.
// Stall: while i_out_ready is low the head result holds and o_in_ready stays low;
// a new item is taken no sooner than the edge taking the last one's final result.

module vector_clock_race_detector #(
    parameter int THREADS       = vcrd_pkg::THREADS_DEF,
    parameter int CLOCK_BITS    = vcrd_pkg::CLOCK_BITS_DEF,
    parameter int LOCATION_BITS = vcrd_pkg::LOCATION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [vcrd_pkg::THR_W-1:0]  i_thread_num,
    input  logic [vcrd_pkg::LOC_W-1:0]  i_location,
    input  logic [vcrd_pkg::VEC_W-1:0]  i_clock_vector,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_race_found,
    output logic [vcrd_pkg::THR_W-1:0]  o_prior_thread,
    output logic [vcrd_pkg::SLOT_W-1:0] o_prior_clock,
    output logic                        o_prior_was_write,
    output logic                        o_now_is_write,
    output logic [vcrd_pkg::LOC_W-1:0]  o_race_location,
    output logic                        o_last
);

    localparam int DEPTH  = 1 << LOCATION_BITS;
    localparam int RD_W   = THREADS * CLOCK_BITS;
    localparam int THR_W  = vcrd_pkg::THR_W;
    localparam int WE_W   = THR_W + CLOCK_BITS;
    localparam int LOC_PW = vcrd_pkg::LOC_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [LOCATION_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic                       r_cmd;
    logic [THR_W-1:0]           r_thread;
    logic [LOCATION_BITS-1:0]   r_idx;
    logic [vcrd_pkg::VEC_W-1:0] r_vec;

    logic                       w_accept;
    logic                       w_free;
    logic                       w_mem_we;
    logic [LOCATION_BITS-1:0]   w_waddr;
    logic [LOCATION_BITS-1:0]   w_raddr;
    logic [WE_W-1:0]            w_we_rdata, w_we_wdata;
    logic [RD_W-1:0]            w_rd_rdata, w_rd_wdata;
    vcrd_pkg::t_race_list       w_list;
    logic                       w_update;
    logic [THR_W-1:0]           w_new_we_thr;
    logic [CLOCK_BITS-1:0]      w_new_we_clk;
    logic [RD_W-1:0]            w_new_rd;
    logic                       w_load;

    assign o_in_ready = (r_state == S_IDLE) && w_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_raddr    = LOCATION_BITS'(i_location);
    assign w_load     = (r_state == S_LOOK);

    // sequencer: clearing sweep, wait for an item, check and write back
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_thread <= i_thread_num;
            r_idx    <= w_raddr;
            r_vec    <= i_clock_vector;
        end
    end

    // write port: zeros during the sweep, updated entry after a check of a valid thread
    assign w_mem_we   = (r_state == S_CLEAR) || ((r_state == S_LOOK) && w_update);
    assign w_waddr    = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign w_we_wdata = (r_state == S_CLEAR) ? '0 : {w_new_we_thr, w_new_we_clk};
    assign w_rd_wdata = (r_state == S_CLEAR) ? '0 : w_new_rd;

    vcrd_ram #(
        .WIDTH (WE_W),
        .DEPTH (DEPTH)
    ) u_write_epoch (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_we_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_we_rdata)
    );

    vcrd_ram #(
        .WIDTH (RD_W),
        .DEPTH (DEPTH)
    ) u_read_clocks (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_rd_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_rdata)
    );

    vcrd_check #(
        .THREADS    (THREADS),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_check (
        .i_is_write   (r_cmd),
        .i_thread     (r_thread),
        .i_vec        (r_vec),
        .i_we_thr     (w_we_rdata[WE_W-1 -: THR_W]),
        .i_we_clk     (w_we_rdata[CLOCK_BITS-1:0]),
        .i_rd         (w_rd_rdata),
        .o_list       (w_list),
        .o_update     (w_update),
        .o_new_we_thr (w_new_we_thr),
        .o_new_we_clk (w_new_we_clk),
        .o_new_rd     (w_new_rd)
    );

    vcrd_results u_results (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_load),
        .i_list            (w_list),
        .i_now_write       (r_cmd),
        .i_location        (LOC_PW'(r_idx)),
        .o_free            (w_free),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_race_found      (o_race_found),
        .o_prior_thread    (o_prior_thread),
        .o_prior_clock     (o_prior_clock),
        .o_prior_was_write (o_prior_was_write),
        .o_now_is_write    (o_now_is_write),
        .o_race_location   (o_race_location),
        .o_last            (o_last)
    );

    // every accepted item is checked on the very next cycle
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted item not checked in the next cycle");

    // a check lasts one cycle and never overlaps the next read
    a_look_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_IDLE))
        else $error("check state held beyond one cycle");

    // nothing moves on either channel during the clearing sweep
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_in_ready && !o_out_valid))
        else $error("channel active during the clearing sweep");

endmodule

### rtl/vcrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vcrd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/vcrd_check.sv
// Race evaluation and shadow entry update for one access.
`timescale 1ns / 1ps

module vcrd_check #(
    parameter int THREADS    = vcrd_pkg::THREADS_DEF,
    parameter int CLOCK_BITS = vcrd_pkg::CLOCK_BITS_DEF,
    localparam int RD_W      = THREADS * CLOCK_BITS
) (
    input  logic                       i_is_write,
    input  logic [vcrd_pkg::THR_W-1:0] i_thread,
    input  logic [vcrd_pkg::VEC_W-1:0] i_vec,
    input  logic [vcrd_pkg::THR_W-1:0] i_we_thr,
    input  logic [CLOCK_BITS-1:0]      i_we_clk,
    input  logic [RD_W-1:0]            i_rd,
    output vcrd_pkg::t_race_list       o_list,
    output logic                       o_update,
    output logic [vcrd_pkg::THR_W-1:0] o_new_we_thr,
    output logic [CLOCK_BITS-1:0]      o_new_we_clk,
    output logic [RD_W-1:0]            o_new_rd
);

    localparam int SW = vcrd_pkg::SLOT_W;
    localparam int NC = vcrd_pkg::MAX_RESULTS + 1;
    localparam logic [vcrd_pkg::THR_W:0] THR_LIM = (vcrd_pkg::THR_W + 1)'(THREADS);

    logic [CLOCK_BITS-1:0] w_slot [4];
    logic [CLOCK_BITS-1:0] w_own;
    logic                  w_thr_ok;
    logic                  w_wr_hit;
    vcrd_pkg::t_report     w_cand [NC];
    logic [NC-1:0]         w_flag;

    // clocks of the current vector, one per thread
    for (genvar g = 0; g < 4; g++) begin : g_slot
        assign w_slot[g] = i_vec[g*SW +: CLOCK_BITS];
    end

    assign w_thr_ok = {1'b0, i_thread} < THR_LIM;
    assign w_own    = w_slot[i_thread];
    assign o_update = w_thr_ok;

    // earlier write races unless ordered before this access
    assign w_wr_hit = w_thr_ok && (i_we_thr != i_thread) && (i_we_clk != '0)
                      && (w_slot[i_we_thr] <= i_we_clk);

    // candidates: read entries in thread order, then the write epoch
    always_comb begin
        logic [CLOCK_BITS-1:0] rc;
        logic                  hit;
        w_flag   = '0;
        o_new_rd = '0;
        for (int p = 0; p < vcrd_pkg::MAX_RESULTS; p++) begin
            w_cand[p] = '0;
        end
        for (int p = 0; p < THREADS; p++) begin
            rc  = i_rd[p*CLOCK_BITS +: CLOCK_BITS];
            hit = (vcrd_pkg::THR_W'(p) != i_thread) && (rc != '0)
                  && (w_slot[p] <= rc);
            w_cand[p].thr       = vcrd_pkg::THR_W'(p);
            w_cand[p].clk       = SW'(rc);
            w_cand[p].was_write = 1'b0;
            w_flag[p]           = hit && w_thr_ok && (i_is_write == vcrd_pkg::CMD_WRITE);
            // a read keeps only the entries it does not subsume
            if (vcrd_pkg::THR_W'(p) == i_thread) begin
                o_new_rd[p*CLOCK_BITS +: CLOCK_BITS] = w_own;
            end else if (hit) begin
                o_new_rd[p*CLOCK_BITS +: CLOCK_BITS] = rc;
            end
        end
        if (i_is_write == vcrd_pkg::CMD_WRITE) begin
            o_new_rd = '0;
        end
        w_cand[NC-1].thr       = i_we_thr;
        w_cand[NC-1].clk       = SW'(i_we_clk);
        w_cand[NC-1].was_write = 1'b1;
        w_flag[NC-1]           = w_wr_hit;
    end

    // pack the races found into reporting order
    always_comb begin
        logic [vcrd_pkg::CNT_W-1:0] pos;
        pos    = '0;
        o_list = '0;
        for (int i = 0; i < NC; i++) begin
            if (w_flag[i] && (pos < vcrd_pkg::CNT_W'(vcrd_pkg::MAX_RESULTS))) begin
                o_list.rep[pos[1:0]] = w_cand[i];
                pos = pos + 1'b1;
            end
        end
        o_list.count = pos;
    end

    // new write epoch: own one on a write, unchanged on a read
    assign o_new_we_thr = (i_is_write == vcrd_pkg::CMD_WRITE) ? i_thread : i_we_thr;
    assign o_new_we_clk = (i_is_write == vcrd_pkg::CMD_WRITE) ? w_own : i_we_clk;

endmodule

### rtl/vcrd_results.sv
// Result buffer: holds the reports of one item and hands them out in order.
`timescale 1ns / 1ps

module vcrd_results (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  vcrd_pkg::t_race_list        i_list,
    input  logic                        i_now_write,
    input  logic [vcrd_pkg::LOC_W-1:0]  i_location,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_race_found,
    output logic [vcrd_pkg::THR_W-1:0]  o_prior_thread,
    output logic [vcrd_pkg::SLOT_W-1:0] o_prior_clock,
    output logic                        o_prior_was_write,
    output logic                        o_now_is_write,
    output logic [vcrd_pkg::LOC_W-1:0]  o_race_location,
    output logic                        o_last
);

    localparam int NR = vcrd_pkg::MAX_RESULTS;

    logic [vcrd_pkg::CNT_W-1:0]   r_count, n_count;
    vcrd_pkg::t_report [NR-1:0]   r_rep, n_rep;
    logic                         r_found, n_found;
    logic                         r_now_write, n_now_write;
    logic [vcrd_pkg::LOC_W-1:0]   r_loc, n_loc;
    logic                         w_pop;

    assign w_pop  = o_out_valid && i_out_ready;
    // empty at the next edge, so a new item may be taken now
    assign o_free = (r_count == '0) || ((r_count == vcrd_pkg::CNT_W'(1)) && i_out_ready);

    // load a fresh item, or shift out the head report
    always_comb begin
        n_count     = r_count;
        n_rep       = r_rep;
        n_found     = r_found;
        n_now_write = r_now_write;
        n_loc       = r_loc;
        if (i_load) begin
            n_count     = (i_list.count == '0) ? vcrd_pkg::CNT_W'(1) : i_list.count;
            n_rep       = i_list.rep;
            n_found     = (i_list.count != '0);
            n_now_write = i_now_write;
            n_loc       = i_location;
        end else if (w_pop) begin
            n_count = r_count - 1'b1;
            for (int i = 0; i < NR - 1; i++) begin
                n_rep[i] = r_rep[i+1];
            end
            n_rep[NR-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep       <= n_rep;
        r_found     <= n_found;
        r_now_write <= n_now_write;
        r_loc       <= n_loc;
    end

    assign o_out_valid       = (r_count != '0);
    assign o_last            = (r_count == vcrd_pkg::CNT_W'(1));
    assign o_race_found      = r_found;
    assign o_prior_thread    = r_rep[0].thr;
    assign o_prior_clock     = r_rep[0].clk;
    assign o_prior_was_write = r_rep[0].was_write;
    assign o_now_is_write    = r_now_write;
    assign o_race_location   = r_loc;

    // a new item only lands in an empty buffer
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_count == '0))
        else $error("result buffer loaded while not empty");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> o_out_valid)
        else $error("loaded item gives no result");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vcrd_pkg::CNT_W'(NR))
        else $error("result count beyond buffer depth");

endmodule
